FILE: hdl/cubic_bezier_eval_split_defines.svh
// Assertion macros used by the block's checker.
`ifndef CUBIC_BEZIER_EVAL_SPLIT_DEFINES_SVH
`define CUBIC_BEZIER_EVAL_SPLIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CBES_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbes check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CBES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbes check failed");

`endif

FILE: hdl/cbes_pkg.sv
// Package: shared types, codes and helpers for the Bezier evaluator.
`default_nettype none
package cbes_pkg;

    localparam int OUT_W    = 40;
    localparam int CMD_W    = 3;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int NUM_TERMS = 4;
    localparam int IDX_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_POINT       = 3'd0,
        CMD_DERIV1      = 3'd1,
        CMD_DERIV2      = 3'd2,
        CMD_SPLIT_START = 3'd3,
        CMD_SPLIT_END   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        SCALE_1 = 2'd0,
        SCALE_3 = 2'd1,
        SCALE_6 = 2'd2
    } scale_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } tag_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [IDX_W-1:0] slot;
        tag_t             tag;
    } ctl_t;

    // Integer weight applied to a floored term (shift-add only)
    function automatic logic signed [OUT_W-1:0] scale_term(
        input logic signed [OUT_W-1:0] v,
        input scale_t                  s
    );
        logic signed [OUT_W-1:0] r;
        begin
            case (s)
                SCALE_3: r = (v <<< 1) + v;
                SCALE_6: r = (v <<< 2) + (v <<< 1);
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cbes_in_if.sv
// Interface: request channel carrying command and curve parameter.
`default_nettype none
interface cbes_in_if #(
    parameter int TW = 17
);
    logic                        valid;
    logic                        ready;
    logic [cbes_pkg::CMD_W-1:0]  command;
    logic [TW-1:0]               t_param;

    modport source (output valid, output command, output t_param, input ready);
    modport sink   (input valid, input command, input t_param, output ready);
endinterface
`default_nettype wire

FILE: hdl/cbes_out_if.sv
// Interface: result channel carrying x,y results, one per point or derivative request and four per split.
`default_nettype none
interface cbes_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cbes_pkg::OUT_W-1:0] out_x;
    logic signed [cbes_pkg::OUT_W-1:0] out_y;
    logic [cbes_pkg::IDX_W-1:0]        point_index;
    logic                              last;

    modport source (output valid, output out_x, output out_y, output point_index,
                    output last, input ready);
    modport sink   (input valid, input out_x, input out_y, input point_index,
                    input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/cbes_front.sv
// Front end: split sequencing and two stages of Bernstein factor products.
`default_nettype none
module cbes_front #(
    parameter int F  = 16,
    parameter int TW = F + 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cbes_in_if.sink                          sample,
    output cbes_pkg::ctl_t                   ctl,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [TW-1:0]                    f_t,
    output logic [TW-1:0]                    f_u,
    output logic [TW-1:0]                    f_t2,
    output logic [TW-1:0]                    f_u2,
    output logic [TW-1:0]                    f_ut,
    output logic [TW-1:0]                    f_t3,
    output logic [TW-1:0]                    f_u3,
    output logic [TW-1:0]                    f_u2t,
    output logic [TW-1:0]                    f_ut2
);
    localparam logic [TW-1:0] ONE = TW'(1) << F;
    localparam logic [cbes_pkg::IDX_W-1:0] LAST_SLOT = cbes_pkg::IDX_W'(cbes_pkg::NUM_TERMS - 1);

    logic [cbes_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic v1_reg, v2_reg;
    cbes_pkg::ctl_t ctl1_reg, ctl2_reg;
    logic [TW-1:0] t1_reg, u1_reg, t21_reg, u21_reg, ut1_reg;
    logic [TW-1:0] t2s_reg, u2s_reg, t22_reg, u22_reg, ut2s_reg;
    logic [TW-1:0] t3_reg, u3_reg, u2t_reg, ut2_reg;

    cbes_pkg::cmd_t cmd;
    logic known, is_split, s1_free, s2_free, issue;
    logic [TW-1:0] tc, uc;
    logic [2*TW-1:0] p_tt, p_uu, p_ut, p_t3, p_u3, p_u2t, p_ut2;
    cbes_pkg::ctl_t ctl_in;

    // decode and split sequencing
    always_comb
    begin
        cmd      = cbes_pkg::cmd_t'(sample.command);
        known    = (sample.command <= cbes_pkg::CMD_SPLIT_END);
        is_split = (cmd == cbes_pkg::CMD_SPLIT_START) || (cmd == cbes_pkg::CMD_SPLIT_END);
        s2_free  = !v2_reg || out_ready;
        s1_free  = !v1_reg || s2_free;
        issue    = sample.valid && known && s1_free;
        sample.ready = !known || (s1_free && (!is_split || slot_reg == LAST_SLOT));
        slot_next = slot_reg;
        if (issue && is_split)
        begin
            slot_next = slot_reg + 1'b1;
        end
        ctl_in.cmd      = cmd;
        ctl_in.slot     = slot_reg;
        ctl_in.tag.idx  = is_split ? slot_reg : '0;
        ctl_in.tag.last = !is_split || (slot_reg == LAST_SLOT);
    end

    // first-level factors
    always_comb
    begin
        tc   = (sample.t_param > ONE) ? ONE : sample.t_param;
        uc   = ONE - tc;
        p_tt = tc * tc;
        p_uu = uc * uc;
        p_ut = uc * tc;
    end

    // second-level factors
    always_comb
    begin
        p_t3  = t21_reg * t1_reg;
        p_u3  = u21_reg * u1_reg;
        p_u2t = u21_reg * t1_reg;
        p_ut2 = u1_reg * t21_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            if (s1_free)
            begin
                v1_reg <= issue;
            end
            if (s2_free)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            ctl1_reg <= ctl_in;
            t1_reg   <= tc;
            u1_reg   <= uc;
            t21_reg  <= p_tt[F+TW-1:F];
            u21_reg  <= p_uu[F+TW-1:F];
            ut1_reg  <= p_ut[F+TW-1:F];
        end
        if (s2_free)
        begin
            ctl2_reg <= ctl1_reg;
            t2s_reg  <= t1_reg;
            u2s_reg  <= u1_reg;
            t22_reg  <= t21_reg;
            u22_reg  <= u21_reg;
            ut2s_reg <= ut1_reg;
            t3_reg   <= p_t3[F+TW-1:F];
            u3_reg   <= p_u3[F+TW-1:F];
            u2t_reg  <= p_u2t[F+TW-1:F];
            ut2_reg  <= p_ut2[F+TW-1:F];
        end
    end

    assign ctl       = ctl2_reg;
    assign out_valid = v2_reg;
    assign f_t       = t2s_reg;
    assign f_u       = u2s_reg;
    assign f_t2      = t22_reg;
    assign f_u2      = u22_reg;
    assign f_ut      = ut2s_reg;
    assign f_t3      = t3_reg;
    assign f_u3      = u3_reg;
    assign f_u2t     = u2t_reg;
    assign f_ut2     = ut2_reg;
endmodule
`default_nettype wire

FILE: hdl/cbes_cell.sv
// Chain cell: one floored term per axis, added to the running sums.
`default_nettype none
module cbes_cell #(
    parameter int AW    = 34,
    parameter int WW    = 18,
    parameter int F     = 16,
    parameter int INDEX = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [3:0][AW-1:0]                in_ax,
    input  wire logic [3:0][AW-1:0]                in_ay,
    input  wire logic [3:0][WW-1:0]                in_w,
    input  cbes_pkg::scale_t [3:0]                 in_sc,
    input  cbes_pkg::tag_t                         in_tag,
    input  wire logic signed [cbes_pkg::OUT_W-1:0] in_sx,
    input  wire logic signed [cbes_pkg::OUT_W-1:0] in_sy,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [3:0][AW-1:0]                     out_ax,
    output logic [3:0][AW-1:0]                     out_ay,
    output logic [3:0][WW-1:0]                     out_w,
    output cbes_pkg::scale_t [3:0]                 out_sc,
    output cbes_pkg::tag_t                         out_tag,
    output logic signed [cbes_pkg::OUT_W-1:0]      out_sx,
    output logic signed [cbes_pkg::OUT_W-1:0]      out_sy
);
    localparam int OW = cbes_pkg::OUT_W;

    logic valid_reg;
    logic [3:0][AW-1:0] ax_reg, ay_reg;
    logic [3:0][WW-1:0] w_reg;
    cbes_pkg::scale_t [3:0] sc_reg;
    cbes_pkg::tag_t tag_reg;
    logic signed [OW-1:0] sx_reg, sy_reg;

    logic signed [AW+WW:0] px, py;
    logic signed [OW-1:0] tx, ty;

    // floor(coord * weight / 2^F), then integer weight
    always_comb
    begin
        px = $signed(in_ax[INDEX]) * $signed({1'b0, in_w[INDEX]});
        py = $signed(in_ay[INDEX]) * $signed({1'b0, in_w[INDEX]});
        tx = cbes_pkg::scale_term(OW'(px >>> F), in_sc[INDEX]);
        ty = cbes_pkg::scale_term(OW'(py >>> F), in_sc[INDEX]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ax_reg  <= in_ax;
            ay_reg  <= in_ay;
            w_reg   <= in_w;
            sc_reg  <= in_sc;
            tag_reg <= in_tag;
            sx_reg  <= in_sx + tx;
            sy_reg  <= in_sy + ty;
        end
    end

    assign out_valid = valid_reg;
    assign out_ax    = ax_reg;
    assign out_ay    = ay_reg;
    assign out_w     = w_reg;
    assign out_sc    = sc_reg;
    assign out_tag   = tag_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
endmodule
`default_nettype wire

FILE: hdl/cubic_bezier_eval_split.sv
// Top level: cubic Bezier point, derivative and split evaluator.
//
//  channel   dir  handshake       payload
//  sample    in   valid/ready     command[2:0], t_param[T_FRAC_BITS:0]
//  result    out  valid/ready     out_x[39:0], out_y[39:0], point_index[1:0], last
//  cfg       in   cfg_we          cfg_index[2:0], cfg_data[COORD_BITS-1:0]
//
// Point and derivative requests issue one result each; split requests issue four
// results, one per control point issued from the front sequencer.
// The pipeline is two factor stages then four chain cells (MAC per cell).
// Reset clears control points to zero and empties the pipeline.
// Every stage holds its data under a stall; bubbles collapse toward the output.
`default_nettype none
module cubic_bezier_eval_split #(
    parameter int COORD_BITS  = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    cbes_in_if.sink                                    sample,
    cbes_out_if.source                                 result,
    input  wire logic                                  cfg_we,
    input  wire logic [cbes_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [COORD_BITS-1:0]                 cfg_data
);
    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int WW = F + 2;
    localparam int AW = COORD_BITS + 2;
    localparam int NT = cbes_pkg::NUM_TERMS;
    localparam logic [WW-1:0] ONE_W = WW'(1) << F;

    logic [COORD_BITS-1:0] cp_reg [cbes_pkg::NUM_REGS];

    cbes_pkg::ctl_t ctl;
    logic fr_valid;
    logic [TW-1:0] f_t, f_u, f_t2, f_u2, f_ut, f_t3, f_u3, f_u2t, f_ut2;

    logic signed [AW-1:0] q [2][NT];
    logic signed [AW-1:0] op [2][NT];
    logic [3:0][WW-1:0] w0;
    cbes_pkg::scale_t [3:0] sc0;
    logic use_point;

    logic                         cv  [NT+1];
    logic                         cr  [NT+1];
    logic [3:0][AW-1:0]           cax [NT+1];
    logic [3:0][AW-1:0]           cay [NT+1];
    logic [3:0][WW-1:0]           cw  [NT+1];
    cbes_pkg::scale_t [3:0]       csc [NT+1];
    cbes_pkg::tag_t               ctag[NT+1];
    logic signed [cbes_pkg::OUT_W-1:0] csx [NT+1];
    logic signed [cbes_pkg::OUT_W-1:0] csy [NT+1];

    // control point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbes_pkg::NUM_REGS; i++)
            begin
                cp_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cp_reg[cfg_index] <= cfg_data;
        end
    end

    cbes_front #(.F(F), .TW(TW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .ctl      (ctl),
        .out_valid(fr_valid),
        .out_ready(cr[0]),
        .f_t      (f_t),
        .f_u      (f_u),
        .f_t2     (f_t2),
        .f_u2     (f_u2),
        .f_ut     (f_ut),
        .f_t3     (f_t3),
        .f_u3     (f_u3),
        .f_u2t    (f_u2t),
        .f_ut2    (f_ut2)
    );

    // term setup: operand, weight and integer scale for each chain cell
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            for (int k = 0; k < NT; k++)
            begin
                q[a][k]  = AW'($signed(cp_reg[k*2 + a]));
                op[a][k] = '0;
            end
        end
        for (int k = 0; k < NT; k++)
        begin
            w0[k]  = '0;
            sc0[k] = cbes_pkg::SCALE_1;
        end
        use_point = 1'b0;
        case (ctl.cmd)
            cbes_pkg::CMD_POINT:
            begin
                use_point = 1'b1;
            end
            cbes_pkg::CMD_DERIV1:
            begin
                for (int a = 0; a < 2; a++)
                begin
                    op[a][0] = q[a][1] - q[a][0];
                    op[a][1] = q[a][2] - q[a][1];
                    op[a][2] = q[a][3] - q[a][2];
                end
                w0[0] = WW'(f_u2);
                w0[1] = WW'(f_ut);
                w0[2] = WW'(f_t2);
                sc0[0] = cbes_pkg::SCALE_3;
                sc0[1] = cbes_pkg::SCALE_6;
                sc0[2] = cbes_pkg::SCALE_3;
            end
            cbes_pkg::CMD_DERIV2:
            begin
                for (int a = 0; a < 2; a++)
                begin
                    op[a][0] = q[a][2] - (q[a][1] <<< 1) + q[a][0];
                    op[a][1] = q[a][3] - (q[a][2] <<< 1) + q[a][1];
                end
                w0[0] = WW'(f_u);
                w0[1] = WW'(f_t);
                sc0[0] = cbes_pkg::SCALE_6;
                sc0[1] = cbes_pkg::SCALE_6;
            end
            cbes_pkg::CMD_SPLIT_START:
            begin
                case (ctl.slot)
                    2'd0:
                    begin
                        for (int a = 0; a < 2; a++) op[a][0] = q[a][0];
                        w0[0] = ONE_W;
                    end
                    2'd1:
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            op[a][0] = q[a][0];
                            op[a][1] = q[a][1];
                        end
                        w0[0] = WW'(f_u);
                        w0[1] = WW'(f_t);
                    end
                    2'd2:
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            op[a][0] = q[a][0];
                            op[a][1] = q[a][1];
                            op[a][2] = q[a][2];
                        end
                        w0[0] = WW'(f_u2);
                        w0[1] = WW'({f_ut, 1'b0});
                        w0[2] = WW'(f_t2);
                    end
                    default:
                    begin
                        use_point = 1'b1;
                    end
                endcase
            end
            cbes_pkg::CMD_SPLIT_END:
            begin
                case (ctl.slot)
                    2'd0:
                    begin
                        use_point = 1'b1;
                    end
                    2'd1:
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            op[a][0] = q[a][1];
                            op[a][1] = q[a][2];
                            op[a][2] = q[a][3];
                        end
                        w0[0] = WW'(f_u2);
                        w0[1] = WW'({f_ut, 1'b0});
                        w0[2] = WW'(f_t2);
                    end
                    2'd2:
                    begin
                        for (int a = 0; a < 2; a++)
                        begin
                            op[a][0] = q[a][2];
                            op[a][1] = q[a][3];
                        end
                        w0[0] = WW'(f_u);
                        w0[1] = WW'(f_t);
                    end
                    default:
                    begin
                        for (int a = 0; a < 2; a++) op[a][0] = q[a][3];
                        w0[0] = ONE_W;
                    end
                endcase
            end
            default:
            begin
                use_point = 1'b0;
            end
        endcase
        // full Bernstein point
        if (use_point)
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int k = 0; k < NT; k++)
                begin
                    op[a][k] = q[a][k];
                end
            end
            w0[0] = WW'(f_u3);
            w0[1] = WW'({f_u2t, 1'b0}) + WW'(f_u2t);
            w0[2] = WW'({f_ut2, 1'b0}) + WW'(f_ut2);
            w0[3] = WW'(f_t3);
        end
    end

    // chain entry
    always_comb
    begin
        cv[0]   = fr_valid;
        cw[0]   = w0;
        csc[0]  = sc0;
        ctag[0] = ctl.tag;
        csx[0]  = '0;
        csy[0]  = '0;
        for (int k = 0; k < NT; k++)
        begin
            cax[0][k] = op[0][k];
            cay[0][k] = op[1][k];
        end
    end

    // row of multiply-accumulate cells
    for (genvar i = 0; i < NT; i++)
    begin : g_cell
        cbes_cell #(.AW(AW), .WW(WW), .F(F), .INDEX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cv[i]),
            .in_ready (cr[i]),
            .in_ax    (cax[i]),
            .in_ay    (cay[i]),
            .in_w     (cw[i]),
            .in_sc    (csc[i]),
            .in_tag   (ctag[i]),
            .in_sx    (csx[i]),
            .in_sy    (csy[i]),
            .out_valid(cv[i+1]),
            .out_ready(cr[i+1]),
            .out_ax   (cax[i+1]),
            .out_ay   (cay[i+1]),
            .out_w    (cw[i+1]),
            .out_sc   (csc[i+1]),
            .out_tag  (ctag[i+1]),
            .out_sx   (csx[i+1]),
            .out_sy   (csy[i+1])
        );
    end

    // last cell is the output register
    assign cr[NT]             = result.ready;
    assign result.valid       = cv[NT];
    assign result.out_x       = csx[NT];
    assign result.out_y       = csy[NT];
    assign result.point_index = ctag[NT].idx;
    assign result.last        = ctag[NT].last;
endmodule
`default_nettype wire

FILE: hdl/cbes_checker.sv
// Checker: port-level properties of the result channel, bound to the top.
`default_nettype none
`include "cubic_bezier_eval_split_defines.svh"
module cbes_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              valid,
    input wire logic                              ready,
    input wire logic [cbes_pkg::OUT_W-1:0]        out_x,
    input wire logic [cbes_pkg::OUT_W-1:0]        out_y,
    input wire logic [cbes_pkg::IDX_W-1:0]        point_index,
    input wire logic                              last
);
    // a stalled result holds its payload
    `CBES_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(out_x) && $stable(out_y) && $stable(point_index) && $stable(last))
    // a final result of a split carries the last control point index
    `CBES_ASSERT_NOW(a_last_idx, valid && last && point_index != 2'd0, point_index == 2'd3)
    // only the final result may carry the last control point index
    `CBES_ASSERT_NOW(a_nonlast_idx, valid && !last, point_index != 2'd3)
endmodule

bind cubic_bezier_eval_split cbes_checker u_cbes_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (result.valid),
    .ready      (result.ready),
    .out_x      (result.out_x),
    .out_y      (result.out_y),
    .point_index(result.point_index),
    .last       (result.last)
);
`default_nettype wire
